[rtl/bhs_pkg.sv]
`default_nettype none
package bhs_pkg;
    localparam int NUM_BUCKETS = 1024;
    localparam int WAYS        = 8;
    localparam int KEY_W       = 31;
    localparam int CFG_W       = 11;
    localparam int IDX_W       = 10;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_UNDEF  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 11'd16;
    localparam logic [0:0]       REG_BUCKET_COUNT   = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic clr;       // clear one fill entry, advance clear pointer
        logic load;      // capture request, start modulo
        logic div_step;  // one restoring-division step
        logic fill_rd;   // register fill of the hashed bucket
        logic slot_rd;   // issue slot read at scan pointer
        logic rd_next;   // slot read at scan pointer + 1
        logic ptr_dec;   // scan pointer down one
        logic ptr_inc;   // scan pointer up one
        logic ins_wr;    // write key at fill position, fill+1
        logic shift_wr;  // write slot ptr with data read from ptr+1
        logic del_fin;   // fill-1
        logic set_found;
        logic res_load;  // capture result
    } bhs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // clear pointer at last bucket
        logic div_done;
        logic ptr_zero;   // scan pointer at zero (delete walking down)
        logic ptr_end;    // scan pointer reached fill (search end)
        logic ptr_last;   // scan pointer + 1 reached fill (shift end)
        logic full;
        logic match;
        logic [OP_W-1:0] op;
    } bhs_stat_t;
endpackage
`default_nettype wire

[rtl/bhs_if.sv]
`default_nettype none
interface bhs_req_if;
    logic                            valid;
    logic                            ready;
    logic [bhs_pkg::OP_W-1:0]        op;
    logic [bhs_pkg::KEY_W-1:0]       key;
    modport source (output valid, op, key, input ready);
    modport sink   (input valid, op, key, output ready);
endinterface

interface bhs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [bhs_pkg::STATUS_W-1:0]    status;
    logic [bhs_pkg::IDX_W-1:0]       bucket_index;
    modport source (output valid, found, status, bucket_index, input ready);
    modport sink   (input valid, found, status, bucket_index, output ready);
endinterface
`default_nettype wire

[rtl/bhs_datapath.sv]
`default_nettype none
module bhs_datapath #(
    parameter int NUM_BUCKETS = bhs_pkg::NUM_BUCKETS,
    parameter int WAYS        = bhs_pkg::WAYS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bhs_pkg::bhs_cmd_t             cmd,
    output bhs_pkg::bhs_stat_t                 stat,
    input  wire logic [bhs_pkg::OP_W-1:0]      in_op,
    input  wire logic [bhs_pkg::KEY_W-1:0]     in_key,
    input  wire logic [bhs_pkg::CFG_W-1:0]     bucket_count,
    output logic                               res_found,
    output logic [bhs_pkg::STATUS_W-1:0]       res_status,
    output logic [bhs_pkg::IDX_W-1:0]          res_index
);
    localparam int KW   = bhs_pkg::KEY_W;
    localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW   = $clog2(WAYS + 1);
    localparam int DW   = $clog2(NUM_BUCKETS + 1);
    localparam int AW   = BW + SW;
    localparam int DEPTH = NUM_BUCKETS * WAYS;
    localparam int CW   = $clog2(KW + 1);

    logic [KW-1:0]  slot_mem [DEPTH];
    logic [FW-1:0]  fill_mem [NUM_BUCKETS];

    logic [bhs_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]  key_reg;
    logic [DW-1:0]  div_reg;
    logic [KW-1:0]  quot_reg;   // shifts out dividend bits
    logic [DW:0]    rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic [BW-1:0]  clr_reg;
    logic [FW-1:0]  fill_reg;
    logic [FW-1:0]  ptr_reg;
    logic [KW-1:0]  rd_reg;
    logic           found_reg;

    // effective bucket count: zero as one, saturated at NUM_BUCKETS
    logic [DW-1:0] eff_count;
    always_comb
    begin
        if (bucket_count == '0)
            eff_count = DW'(1);
        else if ({{(32-bhs_pkg::CFG_W){1'b0}}, bucket_count} > 32'(NUM_BUCKETS))
            eff_count = DW'(NUM_BUCKETS);
        else
            eff_count = DW'(bucket_count);
    end

    logic [DW:0] rem_sh;
    logic [DW:0] rem_sub;
    assign rem_sh  = {rem_reg[DW-1:0], quot_reg[KW-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    logic [BW-1:0] bucket;
    assign bucket = BW'(rem_reg);

    logic [FW-1:0] ptr_plus;
    assign ptr_plus = ptr_reg + FW'(1);

    logic [SW-1:0] slot_idx;
    assign slot_idx = SW'(ptr_reg);
    logic [AW-1:0] slot_addr;
    assign slot_addr = {bucket, slot_idx};
    logic [AW-1:0] next_addr;
    assign next_addr = {bucket, SW'(ptr_plus)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            clr_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_reg <= clr_reg + BW'(1);
            if (cmd.load)
            begin
                cnt_reg   <= CW'(KW);
                found_reg <= 1'b0;
            end
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - CW'(1);
            if (cmd.set_found)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            key_reg  <= in_key;
            quot_reg <= in_key;
            div_reg  <= eff_count;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[KW-2:0], 1'b0};
            rem_reg  <= rem_sub[DW] ? rem_sh : rem_sub;
        end
        if (cmd.fill_rd)
        begin
            fill_reg <= fill_mem[bucket];
            ptr_reg  <= (op_reg == bhs_pkg::OP_DELETE) ? fill_mem[bucket] : '0;
        end
        else if (cmd.ptr_dec)
            ptr_reg <= ptr_reg - FW'(1);
        else if (cmd.ptr_inc)
            ptr_reg <= ptr_plus;
        if (cmd.slot_rd)
            rd_reg <= slot_mem[cmd.rd_next ? next_addr : slot_addr];
        if (cmd.ins_wr)
            slot_mem[{bucket, SW'(fill_reg)}] <= key_reg;
        else if (cmd.shift_wr)
            slot_mem[slot_addr] <= rd_reg;
        if (cmd.clr)
            fill_mem[clr_reg] <= '0;
        else if (cmd.ins_wr)
            fill_mem[bucket] <= fill_reg + FW'(1);
        else if (cmd.del_fin)
            fill_mem[bucket] <= fill_reg - FW'(1);
        if (cmd.res_load)
        begin
            res_index  <= bhs_pkg::IDX_W'(rem_reg);
            res_found  <= found_reg;
            if (op_reg == bhs_pkg::OP_INSERT)
                res_status <= (fill_reg == FW'(WAYS)) ? bhs_pkg::ST_FULL : bhs_pkg::ST_OK;
            else if (op_reg == bhs_pkg::OP_DELETE || op_reg == bhs_pkg::OP_SEARCH)
                res_status <= found_reg ? bhs_pkg::ST_OK : bhs_pkg::ST_NOT_FOUND;
            else
                res_status <= bhs_pkg::ST_OK;
        end
    end

    assign stat.clr_last = (clr_reg == BW'(NUM_BUCKETS - 1));
    assign stat.div_done = (cnt_reg == '0);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.ptr_end  = (ptr_reg == fill_reg);
    assign stat.ptr_last = (ptr_plus == fill_reg);
    assign stat.full     = (fill_reg == FW'(WAYS));
    assign stat.match    = (rd_reg == key_reg);
    assign stat.op       = op_reg;
endmodule
`default_nettype wire

[rtl/bhs_ctrl.sv]
`default_nettype none
module bhs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bhs_pkg::bhs_cmd_t         cmd,
    input  wire bhs_pkg::bhs_stat_t   stat
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIV, S_FILL, S_DISPATCH, S_INS,
        S_DREAD, S_DCMP, S_SHRD, S_SHWR, S_DFIN,
        S_SREAD, S_SCMP, S_RES
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // input taken in idle even while the previous result still waits
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_FILL;
                else
                    cmd.div_step = 1'b1;
            end
            S_FILL:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    bhs_pkg::OP_INSERT: state_next = S_INS;
                    bhs_pkg::OP_DELETE: state_next = stat.ptr_zero ? S_RES : S_DREAD;
                    bhs_pkg::OP_SEARCH: state_next = stat.ptr_end ? S_RES : S_SREAD;
                    default:            state_next = S_RES;
                endcase
                if (stat.op == bhs_pkg::OP_DELETE && !stat.ptr_zero)
                    cmd.ptr_dec = 1'b1;
            end
            S_INS:
            begin
                cmd.ins_wr = !stat.full;
                state_next = S_RES;
            end
            S_DREAD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_DCMP;
            end
            S_DCMP:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_SHRD;
                end
                else if (stat.ptr_zero)
                    state_next = S_RES;
                else
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_DREAD;
                end
            end
            S_SHRD:
            begin
                // fill_reg-1 is last slot; ptr+1 == fill means no more to move
                if (stat.ptr_last)
                    state_next = S_DFIN;
                else
                begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.ptr_inc  = 1'b1;
                state_next   = S_SHRD;
            end
            S_DFIN:
            begin
                cmd.del_fin = 1'b1;
                state_next  = S_RES;
            end
            S_SREAD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_SCMP;
            end
            S_SCMP:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_RES;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_cmd_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins_wr && cmd.shift_wr)) else $error("two slot writes at once");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg) else $error("result dropped");
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> out_valid_reg && state_reg == S_IDLE) else $error("result lost");
    a_found_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_found |-> (state_reg == S_DCMP || state_reg == S_SCMP))
        else $error("found set outside compare");
endmodule
`default_nettype wire

[rtl/bucketed_hash_set.sv]
`default_nettype none
// Bucketed hash set: insert, delete or search a 31-bit key in bucket
// (key mod bucket_count, zero read as one and capped at NUM_BUCKETS), each
// bucket holding up to WAYS keys oldest first. One transaction at a time.
// After reset the fill counts are cleared one bucket per cycle with the
// input held off. The modulo is a restoring divider, one bit per cycle; then
// the fill of the hashed bucket is looked up and the operation dispatched.
// Search compares the slots from the oldest up; delete scans the slots from
// the newest down and then shifts the later slots down by one. The
// controller returns to idle, and a new transaction can be accepted, once
// the result is registered; a result not yet taken stalls only the next
// result, not the input.
module bucketed_hash_set #(
    parameter int NUM_BUCKETS = bhs_pkg::NUM_BUCKETS,
    parameter int WAYS        = bhs_pkg::WAYS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bhs_req_if.sink          req,
    bhs_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    bhs_pkg::bhs_cmd_t  cmd;
    bhs_pkg::bhs_stat_t stat;
    logic [bhs_pkg::CFG_W-1:0] bucket_count_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_count_reg <= bhs_pkg::BUCKET_COUNT_RESET;
        else if (psel && penable && pwrite && paddr == {bhs_pkg::REG_BUCKET_COUNT, 1'b0})
            bucket_count_reg <= pwdata[bhs_pkg::CFG_W-1:0];
    end
    assign prdata = (paddr == {bhs_pkg::REG_BUCKET_COUNT, 1'b0})
                    ? {{(32-bhs_pkg::CFG_W){1'b0}}, bucket_count_reg} : '0;

    bhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    bhs_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_op        (req.op),
        .in_key       (req.key),
        .bucket_count (bucket_count_reg),
        .res_found    (rsp.found),
        .res_status   (rsp.status),
        .res_index    (rsp.bucket_index)
    );
endmodule
`default_nettype wire

[sim/tb_bucketed_hash_set.sv]
module tb_bucketed_hash_set;
    typedef struct {
        logic [bhs_pkg::OP_W-1:0]  op;
        logic [bhs_pkg::KEY_W-1:0] key;
    } hs_request_t;

    typedef struct {
        logic                         found;
        logic [bhs_pkg::STATUS_W-1:0] status;
        logic [bhs_pkg::IDX_W-1:0]    idx;
    } hs_answer_t;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 100;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bhs_req_if req ();
    bhs_rsp_if rsp ();

    bucketed_hash_set DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the table
    logic [bhs_pkg::KEY_W-1:0] shadow_keys [bhs_pkg::NUM_BUCKETS][bhs_pkg::WAYS];
    int unsigned               shadow_fill [bhs_pkg::NUM_BUCKETS];
    logic [bhs_pkg::CFG_W-1:0] shadow_count;

    hs_request_t pend_q[$];
    hs_answer_t  answer_q[$];
    hs_request_t on_bus;
    int          errors;
    bit          no_idle;
    bit          req_acc;
    int          hold_seq;
    int          hold_seen;
    int          hold_cnt;
    int          quiet;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic hs_answer_t lookup_table(input hs_request_t r);
        hs_answer_t  a;
        int unsigned eff;
        int unsigned b;
        int unsigned f;
        eff = shadow_count;
        if (eff == 0)
            eff = 1;
        if (eff > bhs_pkg::NUM_BUCKETS)
            eff = bhs_pkg::NUM_BUCKETS;
        b = r.key % eff;
        f = shadow_fill[b];
        a.found  = 1'b0;
        a.status = bhs_pkg::ST_OK;
        a.idx    = b[bhs_pkg::IDX_W-1:0];
        if (r.op == bhs_pkg::OP_INSERT)
        begin
            if (f < bhs_pkg::WAYS)
            begin
                shadow_keys[b][f] = r.key;
                shadow_fill[b]    = f + 1;
            end
            else
                a.status = bhs_pkg::ST_FULL;
        end
        else if (r.op == bhs_pkg::OP_DELETE)
        begin
            a.status = bhs_pkg::ST_NOT_FOUND;
            for (int i = int'(f) - 1; i >= 0; i--)
            begin
                if (shadow_keys[b][i] == r.key)
                begin
                    for (int j = i; j + 1 < int'(f); j++)
                        shadow_keys[b][j] = shadow_keys[b][j+1];
                    shadow_fill[b] = f - 1;
                    a.found  = 1'b1;
                    a.status = bhs_pkg::ST_OK;
                    break;
                end
            end
        end
        else if (r.op == bhs_pkg::OP_SEARCH)
        begin
            a.status = bhs_pkg::ST_NOT_FOUND;
            for (int i = 0; i < int'(f); i++)
            begin
                if (shadow_keys[b][i] == r.key)
                begin
                    a.found  = 1'b1;
                    a.status = bhs_pkg::ST_OK;
                    break;
                end
            end
        end
        return a;
    endfunction

    // request side: acceptance seen at the rising edge, new item driven at the falling edge
    always @(posedge clk)
    begin
        req_acc = rst_n && req.valid && req.ready;
        if (req_acc)
            answer_q.push_back(lookup_table(on_bus));
    end

    always @(negedge clk)
    begin
        if (rst_n && !(req.valid && !req_acc))
        begin
            if (pend_q.size() > 0 && (no_idle || $urandom_range(99) >= 33))
            begin
                on_bus    = pend_q.pop_front();
                req.op    <= on_bus.op;
                req.key   <= on_bus.key;
                req.valid <= 1'b1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // result side
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_cnt  = 300;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= rst_n && (no_idle || $urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        hs_answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("error at %0t: unexpected transaction", $time);
                errors++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (rsp.found !== want.found)
                    report_mismatch("found", rsp.found, want.found);
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.bucket_index !== want.idx)
                    report_mismatch("bucket_index", rsp.bucket_index, want.idx);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("bucketed_hash_set: mismatch");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == {bhs_pkg::REG_BUCKET_COUNT, 1'b0})
            shadow_count = value[bhs_pkg::CFG_W-1:0];
    endtask

    task automatic push_item(input logic [bhs_pkg::OP_W-1:0] op,
                             input logic [bhs_pkg::KEY_W-1:0] key);
        hs_request_t r;
        r.op  = op;
        r.key = key;
        pend_q.push_back(r);
    endtask

    task automatic drain_table_traffic();
        wait (pend_q.size() == 0 && answer_q.size() == 0 && !req.valid);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_burst(input int n);
        logic [bhs_pkg::KEY_W-1:0] pool [20];
        int                        pick;
        logic [bhs_pkg::OP_W-1:0]  op;
        for (int i = 0; i < 20; i++)
            pool[i] = (i < 10) ? bhs_pkg::KEY_W'($urandom_range(0, 63))
                               : bhs_pkg::KEY_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = bhs_pkg::OP_INSERT;
            else if (pick < 70)
                op = bhs_pkg::OP_DELETE;
            else if (pick < 95)
                op = bhs_pkg::OP_SEARCH;
            else
                op = bhs_pkg::OP_UNDEF;
            if ($urandom_range(9) == 0)
                push_item(op, bhs_pkg::KEY_W'($urandom));
            else
                push_item(op, pool[$urandom_range(19)]);
        end
    endtask

    initial
    begin
        logic [31:0] settings [7];
        errors       = 0;
        no_idle      = 1'b0;
        hold_seq     = 0;
        hold_seen    = 0;
        hold_cnt     = 0;
        quiet        = 0;
        req_acc      = 1'b0;
        shadow_count = bhs_pkg::BUCKET_COUNT_RESET;
        for (int b = 0; b < bhs_pkg::NUM_BUCKETS; b++)
            shadow_fill[b] = 0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 2'd0;
        pwdata    = 32'd0;
        req.valid = 1'b0;
        req.op    = bhs_pkg::OP_INSERT;
        req.key   = '0;
        rsp.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill bucket 0 past capacity, duplicates, extremes, undefined op
        push_item(bhs_pkg::OP_INSERT, 31'd0);
        push_item(bhs_pkg::OP_INSERT, 31'd0);
        for (int i = 1; i <= 6; i++)
            push_item(bhs_pkg::OP_INSERT, bhs_pkg::KEY_W'(16 * i));
        push_item(bhs_pkg::OP_INSERT, 31'd112);
        push_item(bhs_pkg::OP_SEARCH, 31'd0);
        push_item(bhs_pkg::OP_DELETE, 31'd0);
        push_item(bhs_pkg::OP_SEARCH, 31'd0);
        push_item(bhs_pkg::OP_DELETE, 31'd0);
        push_item(bhs_pkg::OP_SEARCH, 31'd0);
        push_item(bhs_pkg::OP_SEARCH, 31'd48);
        push_item(bhs_pkg::OP_DELETE, 31'd5);
        push_item(bhs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
        push_item(bhs_pkg::OP_INSERT, 31'h7FFF_FFFF);
        push_item(bhs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
        push_item(bhs_pkg::OP_DELETE, 31'h7FFF_FFFF);
        push_item(bhs_pkg::OP_UNDEF, 31'h2AAA_AAAA);
        push_item(bhs_pkg::OP_UNDEF, 31'h5555_5555);
        drain_table_traffic();

        // a write to an unused address must be ignored
        reg_write(2'd1, 32'd3);
        random_burst(60);
        drain_table_traffic();

        settings[0] = 32'd1;
        settings[1] = 32'd1024;
        settings[2] = 32'd0;
        settings[3] = 32'hFFFF_FFFF;   // 2047 after masking, saturates
        settings[4] = 32'd5;
        settings[5] = 32'd3;
        settings[6] = $urandom_range(1, 1024);
        for (int p = 0; p < 7; p++)
        begin
            reg_write({bhs_pkg::REG_BUCKET_COUNT, 1'b0}, settings[p]);
            no_idle = (p == 2);
            if (p == 4)
                hold_seq++;
            random_burst(110);
            drain_table_traffic();
        end
        no_idle = 1'b0;

        if (errors == 0)
            $display("bucketed_hash_set: match");
        else
            $display("bucketed_hash_set: mismatch");
        $finish;
    end
endmodule
